[hdl/avs_pkg.sv]
// avs_pkg: widths, register indexes, function codes and reset values
// for the activation value and slope core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package avs_pkg;

  // fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int SLOPE_W    = 13;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // default design parameters
  localparam int FRACTION_BITS_DEF = 12;
  localparam int SIG_ENTRIES_DEF   = 256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_KIND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR   = CFG_IDX_W'(1);

  // function kinds
  localparam logic [KIND_W-1:0] KIND_SIGMOID  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAKY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDENTITY = 2'd2;

  // register reset values
  localparam logic [KIND_W-1:0]  KIND_RST = KIND_SIGMOID;
  localparam logic [SLOPE_W-1:0] LEAK_RST = 13'd410;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SLOPE_W-1:0]  slope_t;

endpackage

`default_nettype wire

[hdl/avs_if.sv]
// avs channel interfaces: sample input, result output, register write
// depends on avs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface avs_in_if;
  import avs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface avs_out_if;
  import avs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t act_value;
  slope_t  act_slope;
  modport source (output valid, output act_value, output act_slope, input ready);
  modport sink   (input valid, input act_value, input act_slope, output ready);
endinterface

interface avs_cfg_if;
  import avs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/avs_sig_rom.sv]
// avs_sig_rom: sigmoid table over [0, 8) with registered read,
// contents computed at elaboration in integer arithmetic; depends on avs_pkg
`timescale 1ns / 1ps
`default_nettype none

module avs_sig_rom #(
  parameter int ENTRIES = avs_pkg::SIG_ENTRIES_DEF,
  parameter int FB      = avs_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [$clog2(ENTRIES)-1:0] addr,
  output logic      [FB:0]                data
);
  import avs_pkg::*;

  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
  localparam logic [63:0] ENTRIES64 = 64'(ENTRIES);

  typedef logic [FB:0] rom_arr_t [ENTRIES];

  // unsigned 64-bit quotient by shift and subtract, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-f), f in [0, 1], both q30, alternating taylor sum
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(Q30_ONE);
    term = Q30_ONE;
    for (int n = 1; n <= 24; n++) begin
      term = udiv64((term * f) >> 30, 64'(n));
      if (n[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t    rom;
    logic [63:0] e1;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] e;
    logic [63:0] den;
    e1 = exp_neg_q30(Q30_ONE);
    for (int i = 0; i < ENTRIES; i++) begin
      t = udiv64(64'(i) << 33, ENTRIES64);
      k = t >> 30;
      e = exp_neg_q30(t & (Q30_ONE - 64'd1));
      for (int j = 0; j < 8; j++) begin
        if (64'(j) < k) begin
          e = (e * e1) >> 30;
        end
      end
      den    = Q30_ONE + e;
      rom[i] = (FB+1)'(udiv64((64'd1 << (FB + 30)) + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

`default_nettype wire

[hdl/activation_value_and_slope_core.sv]
// activation_value_and_slope_core: sigmoid / leaky relu / identity with slope
// depends on avs_pkg, avs_if (channel interfaces) and avs_sig_rom
//
//  channel | dir | payload                         | transfer when
//  --------+-----+---------------------------------+---------------------
//  in_ch   | in  | sample_in  s16 q4.12            | valid && ready
//  out_ch  | out | act_value s16, act_slope u13    | valid && ready
//  cfg_ch  | in  | index u4, data u16              | valid (ready tied high)
//
// two register stages: one item per cycle while the output is not stalled;
// an accepted item is held in the first stage, then in the output register,
// where out valid rises; the sigmoid table's registered read sets the first
// stage, the slope multiply the second
// rst_n is synchronous; it empties both stages and loads the register defaults
// a stalled output holds in place and the first stage keeps accepting until
// it is also full, so no item is dropped or repeated under back pressure
`timescale 1ns / 1ps
`default_nettype none

module activation_value_and_slope_core #(
  parameter int SIGMOID_TABLE_ENTRIES = avs_pkg::SIG_ENTRIES_DEF,
  parameter int FRACTION_BITS         = avs_pkg::FRACTION_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  avs_in_if.sink   in_ch,
  avs_out_if.source out_ch,
  avs_cfg_if.sink  cfg_ch
);
  import avs_pkg::*;

  localparam int FB     = FRACTION_BITS;
  localparam int IDX_W  = $clog2(SIGMOID_TABLE_ENTRIES);
  localparam int MAG_W  = SAMPLE_W + 1;                 // |x| up to 32768
  localparam int PIDX_W = MAG_W + IDX_W + 1;            // |x| * entries
  localparam int LK_W   = MAG_W + SLOPE_W + 1;          // |x| * leak, rounded up
  localparam int PW     = 2 * FB + 2;                   // s * (one - s)
  localparam int SW_W   = FB + SAMPLE_W + 1;            // sigmoid value, widened

  localparam logic [FB:0]         ONE       = (FB+1)'(1) << FB;
  localparam logic [SLOPE_W-1:0]  ONE_SLOPE = SLOPE_W'(64'd1 << FB);
  localparam logic [MAG_W+4:0]    SAT_LIM   = (MAG_W+5)'(64'd1 << (FB + 3));
  localparam logic [PIDX_W-1:0]   ENT_P     = PIDX_W'(SIGMOID_TABLE_ENTRIES);
  localparam logic [PIDX_W-1:0]   LAST_P    = PIDX_W'(SIGMOID_TABLE_ENTRIES - 1);
  localparam logic [LK_W-1:0]     RND_UP    = LK_W'((64'd1 << FB) - 64'd1);
  localparam logic [LK_W-1:0]     NEG_LIM   = LK_W'(32768);
  localparam logic [PW-1:0]       HALF      = PW'(64'd1 << (FB - 1));
  localparam logic [SW_W-1:0]     VMAX      = SW_W'(32767);

  // ---------------- configuration registers ----------------
  logic [KIND_W-1:0]  kind_r;
  logic [SLOPE_W-1:0] leak_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_RST;
      leak_r <= LEAK_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FUNCTION_KIND: kind_r <= cfg_ch.data[KIND_W-1:0];
        REG_LEAK_FACTOR:   leak_r <= cfg_ch.data[SLOPE_W-1:0];
        default: ;  // unknown index is ignored
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_r;
  logic out_valid_r;
  logic adv_out;   // stage 1 moves into the output register
  logic adv_s1;    // stage 1 takes a new item (or empties)

  assign adv_out     = !out_valid_r || out_ch.ready;
  assign adv_s1      = !s1_valid_r || adv_out;
  assign in_ch.ready = adv_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // ---------------- stage 1: table index, leaky multiply ----------------
  sample_t           x;
  logic [MAG_W-1:0]  mag;
  logic [PIDX_W-1:0] pidx;
  logic [PIDX_W-1:0] idx_full;
  logic [IDX_W-1:0]  rom_addr;
  logic              sat_nxt;
  logic [LK_W-1:0]   lk_prod;
  logic [LK_W-1:0]   lk_q;
  sample_t           lk_val_nxt;

  assign x   = in_ch.sample_in;
  assign mag = x[SAMPLE_W-1] ? (MAG_W'(0) - MAG_W'(x)) : MAG_W'(x);

  always_comb begin
    // sigmoid: truncating index into [0, 8), clamped to the last entry
    pidx     = PIDX_W'(mag) * ENT_P;
    idx_full = pidx >> (FB + 3);
    if (idx_full >= ENT_P) begin
      rom_addr = IDX_W'(LAST_P);
    end else begin
      rom_addr = idx_full[IDX_W-1:0];
    end
    sat_nxt = ((MAG_W+5)'(mag) >= SAT_LIM);

    // leaky relu, non-positive side: -ceil(|x| * leak / one), floor at -32768
    lk_prod = LK_W'(mag) * LK_W'(leak_r);
    lk_q    = (lk_prod + RND_UP) >> FB;
    if (lk_q >= NEG_LIM) begin
      lk_val_nxt = sample_t'(16'sh8000);
    end else begin
      lk_val_nxt = sample_t'(SAMPLE_W'(0) - lk_q[SAMPLE_W-1:0]);
    end
  end

  sample_t            x_r;
  logic [KIND_W-1:0]  kind_s1_r;
  logic               sat_r;
  sample_t            lk_val_r;
  slope_t             leak_s1_r;
  logic [FB:0]        rom_q;

  avs_sig_rom #(
    .ENTRIES (SIGMOID_TABLE_ENTRIES),
    .FB      (FB)
  ) u_sig_rom (
    .clk  (clk),
    .en   (adv_s1),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      x_r       <= x;
      kind_s1_r <= kind_r;
      sat_r     <= sat_nxt;
      lk_val_r  <= lk_val_nxt;
      leak_s1_r <= leak_r;
    end
  end

  // ---------------- stage 2: sigmoid symmetry, slope, select ----------------
  logic            x_neg;
  logic            x_pos;
  logic [FB:0]     sig_s;
  logic [SW_W-1:0] sig_wide;
  logic [PW-1:0]   sig_prod;
  logic [PW-1:0]   sig_slope;
  sample_t         value_nxt;
  slope_t          slope_nxt;

  assign x_neg = x_r[SAMPLE_W-1];
  assign x_pos = !x_neg && (x_r != sample_t'(0));

  always_comb begin
    // s(-x) = 1 - s(x); beyond |x| >= 8 saturate to one or zero
    if (sat_r) begin
      sig_s = x_pos ? ONE : (FB+1)'(0);
    end else if (x_neg) begin
      sig_s = ONE - rom_q;
    end else begin
      sig_s = rom_q;
    end
    sig_wide  = SW_W'(sig_s);
    sig_prod  = PW'(sig_s) * PW'(ONE - sig_s);
    sig_slope = (sig_prod + HALF) >> FB;

    case (kind_s1_r)
      KIND_SIGMOID: begin
        if (sig_wide > VMAX) begin
          value_nxt = sample_t'(16'sh7fff);
        end else begin
          value_nxt = sample_t'(sig_wide[SAMPLE_W-1:0]);
        end
        slope_nxt = sig_slope[SLOPE_W-1:0];
      end
      KIND_LEAKY: begin
        if (x_pos) begin
          value_nxt = x_r;
          slope_nxt = ONE_SLOPE;
        end else begin
          value_nxt = lk_val_r;
          slope_nxt = leak_s1_r;
        end
      end
      default: begin
        // identity, also for the unused code
        value_nxt = x_r;
        slope_nxt = ONE_SLOPE;
      end
    endcase
  end

  // ---------------- output register ----------------
  sample_t act_value_r;
  slope_t  act_slope_r;

  always_ff @(posedge clk) begin
    if (adv_out) begin
      act_value_r <= value_nxt;
      act_slope_r <= slope_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.act_value = act_value_r;
  assign out_ch.act_slope = act_slope_r;

endmodule

`default_nettype wire

[hdl/avs_chk.sv]
// avs_chk: port-level checks on the activation value and slope core,
// bound to the top level; depends on avs_pkg
`timescale 1ns / 1ps
`default_nettype none

module avs_chk (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire avs_pkg::sample_t act_value,
  input wire avs_pkg::slope_t  act_slope
);
  import avs_pkg::*;

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // an empty output register always lets the first stage drain
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(act_value) && $stable(act_slope))
    else $error("result changed while stalled");

endmodule

bind activation_value_and_slope_core avs_chk u_avs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .act_value (out_ch.act_value),
  .act_slope (out_ch.act_slope)
);

`default_nettype wire
